@@ hw/rtl/pil_pkg.sv @@
// shared types and constants for the positional integer list
`default_nettype none

package pil_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int CMD_QUEUE_DEPTH  = 2;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int FIDX_W   = 6;
  localparam int COUNT_W  = 7;

  // position code that means the last element, or append for insert
  localparam logic [POS_W-1:0] POS_LAST = '1;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // decoded request word passed from front to back
  typedef struct packed {
    op_t                op;
    logic               last;
    logic               badpos;
    logic [POS_W-2:0]   pos;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_INS_SHIFT,
    BK_INS_PLACE,
    BK_RD_WAIT,
    BK_REM_SHIFT,
    BK_FIND_SCAN,
    BK_RESULT
  } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pil_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module pil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/pil_front.sv @@
// front end: accepts request words and classifies them
`default_nettype none

module pil_front (
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [pil_pkg::MODE_W-1:0]    mode,
  input  wire logic signed [pil_pkg::POS_W-1:0] position,
  input  wire logic signed [pil_pkg::VAL_W-1:0] value,
  input  wire logic                          q_full,
  output logic                               q_wr,
  output pil_pkg::cmd_t                      q_cmd
);

  import pil_pkg::*;

  logic is_last;

  assign is_last = (position == POS_LAST);

  always_comb begin
    q_cmd.op     = op_t'(mode);
    q_cmd.last   = is_last;
    // negative positions other than last are rejected, find ignores position
    q_cmd.badpos = (op_t'(mode) != OP_FIND) && position[POS_W-1] && !is_last;
    q_cmd.pos    = position[POS_W-2:0];
    q_cmd.value  = value;
  end

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule

`default_nettype wire

@@ hw/rtl/pil_cmd_queue.sv @@
// short request queue between front and back
`default_nettype none

module pil_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  pil_pkg::cmd_t      wr_cmd,
  output logic               full,
  input  wire logic          rd,
  output pil_pkg::cmd_t      rd_cmd,
  output logic               valid
);

  import pil_pkg::*;

  localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t          slots [CMD_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign full   = (fill == NW'(CMD_QUEUE_DEPTH));
  assign valid  = (fill != '0);
  assign rd_cmd = slots[rd_ptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(CMD_QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + NW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pil_back.sv @@
// back end: runs each request against the element ram and holds the result word
`default_nettype none

module pil_back #(
  parameter int CAPACITY = pil_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  pil_pkg::cmd_t                         q_cmd,
  output logic                                  q_pop,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic [pil_pkg::STATUS_W-1:0]          status,
  output logic signed [pil_pkg::VAL_W-1:0]      value_out,
  output logic [pil_pkg::FIDX_W-1:0]            found_index,
  output logic [pil_pkg::COUNT_W-1:0]           count
);

  import pil_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int FXW  = (IW > FIDX_W) ? IW : FIDX_W;
  localparam int OXW  = (CW > COUNT_W) ? CW : COUNT_W;

  back_state_t      state;
  back_state_t      state_next;
  cmd_t             cmd;
  logic [CW-1:0]    occ;
  logic [CW-1:0]    occ_next;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_next;
  logic [IW-1:0]    at;
  logic [IW-1:0]    at_next;
  status_t          res_status;
  status_t          res_status_next;
  logic [VAL_W-1:0] res_vout;
  logic [VAL_W-1:0] res_vout_next;
  logic [FIDX_W-1:0] res_fidx;
  logic [FIDX_W-1:0] res_fidx_next;

  logic             out_valid;
  status_t          out_status;
  logic [VAL_W-1:0] out_vout;
  logic [FIDX_W-1:0] out_fidx;
  logic [COUNT_W-1:0] out_count;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [CMPW-1:0]  occ_w;
  logic [CMPW-1:0]  pos_w;
  logic [CMPW-1:0]  ins_at_w;
  logic [CMPW-1:0]  rem_at_w;
  logic [CW-1:0]    occ_m1;
  logic             is_empty;
  logic             is_full;
  logic             ins_append;
  logic             rem_bad;
  logic             idx_last;
  logic             at_last;
  logic             find_hit;
  logic             slot_free;
  logic             load_out;
  logic [FXW-1:0]   idx_x;
  logic [OXW-1:0]   occ_x;

  pil_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request classification against the current count
  assign occ_w      = CMPW'(occ);
  assign pos_w      = CMPW'(cmd.pos);
  assign occ_m1     = occ - CW'(1);
  assign is_empty   = (occ == '0);
  assign is_full    = (occ_w >= CMPW'(CAPACITY));
  assign ins_at_w   = (cmd.last || pos_w >= occ_w) ? occ_w : pos_w;
  assign ins_append = (ins_at_w == occ_w);
  assign rem_at_w   = cmd.last ? occ_w - CMPW'(1) : pos_w;
  assign rem_bad    = (rem_at_w >= occ_w);
  assign idx_last   = (CW'(idx) == occ_m1);
  assign at_last    = (CW'(at) == occ_m1);
  assign find_hit   = (ram_rdata == cmd.value);
  assign slot_free  = !out_valid || pop;
  assign idx_x      = FXW'(idx);
  assign occ_x      = OXW'(occ);
  assign load_out   = (state == BK_RESULT) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        case (cmd.op)
          OP_FIND: begin
            state_next = is_empty ? BK_RESULT : BK_FIND_SCAN;
          end
          OP_INSERT: begin
            if (cmd.badpos || is_full || ins_append) begin
              state_next = BK_RESULT;
            end else begin
              state_next = BK_INS_SHIFT;
            end
          end
          default: begin
            if (cmd.badpos || is_empty || rem_bad) begin
              state_next = BK_RESULT;
            end else begin
              state_next = BK_RD_WAIT;
            end
          end
        endcase
      end
      BK_INS_SHIFT: begin
        if (idx == at) begin
          state_next = BK_INS_PLACE;
        end
      end
      BK_INS_PLACE: begin
        state_next = BK_RESULT;
      end
      BK_RD_WAIT: begin
        if (cmd.op == OP_READ || at_last) begin
          state_next = BK_RESULT;
        end else begin
          state_next = BK_REM_SHIFT;
        end
      end
      BK_REM_SHIFT: begin
        if (idx_last) begin
          state_next = BK_RESULT;
        end
      end
      BK_FIND_SCAN: begin
        if (find_hit || idx_last) begin
          state_next = BK_RESULT;
        end
      end
      BK_RESULT: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = ram_rdata;
    ram_raddr       = idx;
    occ_next        = occ;
    idx_next        = idx;
    at_next         = at;
    res_status_next = res_status;
    res_vout_next   = res_vout;
    res_fidx_next   = res_fidx;
    case (state)
      BK_IDLE: begin
        q_pop = q_valid;
      end
      BK_DECIDE: begin
        res_status_next = ST_OK;
        res_vout_next   = '0;
        res_fidx_next   = '0;
        case (cmd.op)
          OP_FIND: begin
            if (is_empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              ram_raddr = '0;
              idx_next  = '0;
            end
          end
          OP_INSERT: begin
            if (cmd.badpos) begin
              res_status_next = ST_BADPOS;
            end else if (is_full) begin
              res_status_next = ST_FULL;
            end else if (ins_append) begin
              ram_we    = 1'b1;
              ram_waddr = occ[IW-1:0];
              ram_wdata = cmd.value;
              occ_next  = occ + CW'(1);
            end else begin
              // shift the tail up one place, starting from the back
              at_next   = ins_at_w[IW-1:0];
              ram_raddr = occ_m1[IW-1:0];
              idx_next  = occ_m1[IW-1:0];
            end
          end
          default: begin
            // bad negative position first, then empty list, then past the count
            if (cmd.badpos) begin
              res_status_next = ST_BADPOS;
            end else if (is_empty) begin
              res_status_next = ST_EMPTY;
            end else if (rem_bad) begin
              res_status_next = ST_BADPOS;
            end else begin
              at_next   = rem_at_w[IW-1:0];
              ram_raddr = rem_at_w[IW-1:0];
            end
          end
        endcase
      end
      BK_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx + IW'(1);
        ram_wdata = ram_rdata;
        if (idx != at) begin
          ram_raddr = idx - IW'(1);
          idx_next  = idx - IW'(1);
        end
      end
      BK_INS_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = at;
        ram_wdata = cmd.value;
        occ_next  = occ + CW'(1);
      end
      BK_RD_WAIT: begin
        res_vout_next = ram_rdata;
        if (cmd.op != OP_READ) begin
          if (at_last) begin
            occ_next = occ_m1;
          end else begin
            // close the gap, pulling each later element down one place
            ram_raddr = at + IW'(1);
            idx_next  = at + IW'(1);
          end
        end
      end
      BK_REM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx - IW'(1);
        ram_wdata = ram_rdata;
        if (idx_last) begin
          occ_next = occ_m1;
        end else begin
          ram_raddr = idx + IW'(1);
          idx_next  = idx + IW'(1);
        end
      end
      BK_FIND_SCAN: begin
        if (find_hit) begin
          res_fidx_next = idx_x[FIDX_W-1:0];
        end else if (idx_last) begin
          res_status_next = ST_NOTFOUND;
        end else begin
          ram_raddr = idx + IW'(1);
          idx_next  = idx + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    idx        <= idx_next;
    at         <= at_next;
    res_status <= res_status_next;
    res_vout   <= res_vout_next;
    res_fidx   <= res_fidx_next;
    if (load_out) begin
      out_status <= res_status;
      out_vout   <= res_vout;
      out_fidx   <= res_fidx;
      out_count  <= occ_x[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty       = !out_valid;
  assign status      = out_status;
  assign value_out   = out_vout;
  assign found_index = out_fidx;
  assign count       = out_count;

endmodule

`default_nettype wire

@@ hw/rtl/positional_integer_list.sv @@
// top level of the positional integer list
//
// an ordered list of up to CAPACITY signed 32-bit values, packed from index
// 0 (front) to count-1 (back). each request word is insert, remove, read or
// find, and yields exactly one result word carrying a status, the value
// removed or read, the index found, and the element count after the request.
// both sides behave as queues: a request is taken when push is high and full
// is low; a result is presented while empty is low and is taken with pop.
// the front decodes each word and screens bad negative positions, a two-deep
// request queue decouples it from the back, and the back executes requests
// one at a time against a single-port-write, registered-read element ram.
// insert and remove move the elements behind the position one ram entry per
// cycle and find scans one entry per cycle, so the ram port sets the pace.
// the element ram is not cleared at reset; only entries below the count
// are ever used.
`default_nettype none

module positional_integer_list #(
  parameter int CAPACITY = pil_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request side
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [pil_pkg::MODE_W-1:0]       mode,
  input  wire logic signed [pil_pkg::POS_W-1:0] position,
  input  wire logic signed [pil_pkg::VAL_W-1:0] value,
  // result side
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [pil_pkg::STATUS_W-1:0]          status,
  output logic signed [pil_pkg::VAL_W-1:0]      value_out,
  output logic [pil_pkg::FIDX_W-1:0]            found_index,
  output logic [pil_pkg::COUNT_W-1:0]           count
);

  import pil_pkg::*;

  // front to queue
  logic q_wr;
  logic q_full;
  cmd_t q_wr_cmd;

  // queue to back
  logic q_valid;
  logic q_pop;
  cmd_t q_rd_cmd;

  // decode and screen incoming words
  pil_front u_front (
    .push     (push),
    .full     (full),
    .mode     (mode),
    .position (position),
    .value    (value),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_cmd    (q_wr_cmd)
  );

  // decoupling queue, lets the front keep taking words while the back works
  pil_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd     (q_pop),
    .rd_cmd (q_rd_cmd),
    .valid  (q_valid)
  );

  // execution engine with element storage and the result word register
  pil_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_rd_cmd),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .status      (status),
    .value_out   (value_out),
    .found_index (found_index),
    .count       (count)
  );

endmodule

`default_nettype wire

@@ verif/tb_positional_integer_list.sv @@
// self-checking testbench for the positional integer list
`timescale 1ns / 1ps

module tb_positional_integer_list;
  import pil_pkg::*;

  localparam int LIST_CAP    = DEFAULT_CAPACITY;
  localparam int RANDOM_REQS = 1280;
  localparam int PHASE_LEN   = 160;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_WAIT = 80;

  // one request word as queued for the driver
  typedef struct packed {
    op_t                     op;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] value;
  } list_req_t;

  // one result word as the list should answer it
  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] value_out;
    logic [FIDX_W-1:0]       fidx;
    logic [COUNT_W-1:0]      cnt;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      push = 1'b0;
  logic                      full;
  logic [MODE_W-1:0]         mode = '0;
  logic signed [POS_W-1:0]   position = '0;
  logic signed [VAL_W-1:0]   value = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic signed [VAL_W-1:0]   value_out;
  logic [FIDX_W-1:0]         found_index;
  logic [COUNT_W-1:0]        count;

  // request words waiting for the driver, and answers waiting for the monitor
  list_req_t                 req_q[$];
  list_result_t              due_results[$];

  // predictor's own copy of the list contents, front at index 0
  logic signed [VAL_W-1:0]   held_values[$];

  int words_in    = 0;
  int words_out   = 0;
  int mismatches  = 0;
  int cycles      = 0;
  int peak_count  = 0;
  int op_hits[4]     = '{default: 0};
  int status_hits[5] = '{default: 0};

  // a long stretch in the middle of the run where neither side takes random idle breaks
  logic calm;
  assign calm = (words_in >= 500) && (words_in < 800);

  always #5 clk = ~clk;

  positional_integer_list uut (
    clk, rst, push, full, mode, position, value,
    empty, pop, status, value_out, found_index, count
  );

  // random idle decision shared by both sides, true with odds of about 8 in 100 outside the calm stretch
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 8);
  endfunction

  // list predictor: applies one request to held_values and returns the answer
  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int           n;
    int           p;
    int           at;
    bit           hit;
    res = '0;
    res.status = ST_OK;
    n = held_values.size();
    p = r.pos;
    if (r.op == OP_FIND) begin
      // find ignores the position field entirely
      if (n == 0) begin
        res.status = ST_EMPTY;
      end else begin
        hit = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!hit && held_values[i] == r.value) begin
            hit = 1'b1;
            res.fidx = i;
          end
        end
        if (!hit) res.status = ST_NOTFOUND;
      end
    end else if (p < -1) begin
      // negative positions other than the last-element code are refused first
      res.status = ST_BADPOS;
    end else if (r.op == OP_INSERT) begin
      if (n >= LIST_CAP) begin
        res.status = ST_FULL;
      end else if (p == -1 || p >= n) begin
        held_values.push_back(r.value);
      end else begin
        held_values.insert(p, r.value);
      end
    end else if (n == 0) begin
      res.status = ST_EMPTY;
    end else begin
      at = (p == -1) ? n - 1 : p;
      if (at >= n) begin
        res.status = ST_BADPOS;
      end else begin
        res.value_out = held_values[at];
        if (r.op == OP_REMOVE) held_values.delete(at);
      end
    end
    res.cnt = held_values.size();
    return res;
  endfunction

  // data values: extremes, a small pool that forces duplicates, or anything
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hffff_ffff;
        2: return 32'h8000_0000;
        default: return 32'h7fff_ffff;
      endcase
    end
    if (r < 35) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // positions: last code, inside the list, at or past the end, or bad negatives
  function automatic logic signed [POS_W-1:0] pick_position(int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return -1;
    if (r < 70) return (n == 0) ? 0 : $urandom_range(0, (n > 64 ? 64 : n) - 1);
    if (r < 85) return (n >= 63) ? $urandom_range(0, 63) : $urandom_range(n, 63);
    return -int'($urandom_range(2, 64));
  endfunction

  // driver: holds a word until taken, then maybe idles before the next one
  always @(posedge clk) begin : drive
    list_result_t res;
    logic         holding;
    if (rst) begin
      push <= 1'b0;
    end else begin
      holding = push;
      if (push && !full) begin
        // word taken: predict its answer now, in acceptance order
        res = apply_request(req_q[0]);
        due_results.push_back(res);
        op_hits[req_q[0].op]++;
        if (res.cnt > peak_count) peak_count = res.cnt;
        void'(req_q.pop_front());
        words_in++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (req_q.size() != 0 && !take_break()) begin
          push     <= 1'b1;
          mode     <= req_q[0].op;
          position <= req_q[0].pos;
          value    <= req_q[0].value;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every taken result word against the oldest prediction
  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_out++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word with nothing pending: status %0d value_out %0d index %0d count %0d",
                     status, value_out, found_index, count);
        end else begin
          want = due_results.pop_front();
          status_hits[want.status]++;
          if (status !== want.status || value_out !== want.value_out ||
              found_index !== want.fidx || count !== want.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: want status %0d value_out %0d index %0d count %0d, got status %0d value_out %0d index %0d count %0d",
                       words_out, want.status, want.value_out, want.fidx, want.cnt,
                       status, value_out, found_index, count);
          end
        end
      end
      pop <= !take_break();
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d answers outstanding", cycles,
               due_results.size());
      $display("** positional_integer_list: FAILED **");
      $finish;
    end
  end

  // stimulus, end-of-run wait and verdict
  initial begin : stimulus
    list_req_t r;
    int        phase;
    int        n;
    int        pick;
    int        ins_pct;
    int        rem_pct;
    int        rd_pct;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list answers for remove, read and find
    req_q.push_back('{OP_REMOVE, -7'sd1,  32'sd0});
    req_q.push_back('{OP_READ,   7'sd0,   32'sd0});
    req_q.push_back('{OP_FIND,   7'sd0,   32'sd5});
    // bad negative positions win over everything else
    req_q.push_back('{OP_INSERT, -7'sd2,  32'sd1});
    req_q.push_back('{OP_REMOVE, -7'sd64, 32'sd0});
    // inserts: front, append by last code, append past the end, front, middle, middle
    req_q.push_back('{OP_INSERT, 7'sd0,   32'h7fff_ffff});
    req_q.push_back('{OP_INSERT, -7'sd1,  32'h8000_0000});
    req_q.push_back('{OP_INSERT, 7'sd63,  32'sd0});
    req_q.push_back('{OP_INSERT, 7'sd0,   -32'sd1});
    req_q.push_back('{OP_INSERT, 7'sd2,   32'sd5});
    req_q.push_back('{OP_INSERT, 7'sd4,   32'sd5});
    // find: first of two matches, extreme value, a miss, position ignored
    req_q.push_back('{OP_FIND,   7'sd0,   32'sd5});
    req_q.push_back('{OP_FIND,   7'sd9,   32'h8000_0000});
    req_q.push_back('{OP_FIND,   7'sd0,   32'sd1234});
    req_q.push_back('{OP_FIND,   -7'sd64, -32'sd1});
    // reads: last, at the count, far past it, front
    req_q.push_back('{OP_READ,   -7'sd1,  32'sd0});
    req_q.push_back('{OP_READ,   7'sd6,   32'sd0});
    req_q.push_back('{OP_READ,   7'sd63,  32'sd0});
    req_q.push_back('{OP_READ,   7'sd0,   32'sd0});
    // removing the tail by index must leave the back pointer usable
    req_q.push_back('{OP_REMOVE, 7'sd5,   32'sd0});
    req_q.push_back('{OP_INSERT, -7'sd1,  32'sd7});
    req_q.push_back('{OP_READ,   -7'sd1,  32'sd0});
    req_q.push_back('{OP_REMOVE, 7'sd0,   32'sd0});
    req_q.push_back('{OP_REMOVE, -7'sd1,  32'sd0});
    req_q.push_back('{OP_REMOVE, 7'sd2,   32'sd0});

    // random: fill, mixed, drain, mixed phases so full and empty both recur;
    // words are made a few ahead so choices track the live list contents
    for (int i = 0; i < RANDOM_REQS; i++) begin
      while (req_q.size() >= 3) @(negedge clk);
      phase = (i / PHASE_LEN) % 4;
      case (phase)
        0: begin ins_pct = 80; rem_pct = 88; rd_pct = 94; end
        2: begin ins_pct = 10; rem_pct = 80; rd_pct = 90; end
        default: begin ins_pct = 35; rem_pct = 55; rd_pct = 75; end
      endcase
      n = held_values.size();
      pick = $urandom_range(0, 99);
      r.op = (pick < ins_pct) ? OP_INSERT :
             (pick < rem_pct) ? OP_REMOVE :
             (pick < rd_pct)  ? OP_READ   : OP_FIND;
      r.pos = pick_position(n);
      r.value = pick_value();
      // most finds look for something that is actually held
      if (r.op == OP_FIND && n != 0 && $urandom_range(0, 99) < 65)
        r.value = held_values[$urandom_range(0, n - 1)];
      req_q.push_back(r);
    end

    // everything sent, every answer back, then a quiet spell for strays
    while (req_q.size() != 0 || push) @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);

    $display("ran %0d requests (insert %0d, remove %0d, read %0d, find %0d), peak count %0d",
             words_in, op_hits[OP_INSERT], op_hits[OP_REMOVE], op_hits[OP_READ],
             op_hits[OP_FIND], peak_count);
    $display("answers: ok %0d, empty %0d, bad position %0d, full %0d, not found %0d; %0d mismatches",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BADPOS],
             status_hits[ST_FULL], status_hits[ST_NOTFOUND], mismatches);
    if (mismatches == 0) begin
      $display("** positional_integer_list: PASSED **");
    end else begin
      $display("** positional_integer_list: FAILED **");
    end
    $finish;
  end

endmodule
